// ===== rtl/core/csb_pkg.sv =====
// Shared widths, types and the CORDIC arctangent table for the compass sector unit.
package csb_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 24;

  localparam int unsigned LAT_W  = 28;
  localparam int unsigned LON_W  = 29;
  localparam int unsigned DLON_W = 30;
  localparam int unsigned HW_W   = 6;
  localparam int unsigned DIR_W  = 4;
  localparam int unsigned NUM_W  = 34;
  localparam int unsigned DEN_W  = 35;

  typedef logic signed [31:0] q30_t;

  // Arctangent of 2^-i as a binary angle, full turn = 2^32
  localparam logic [31:0] ATAN_BAM [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

// ===== rtl/core/csb_sincos.sv =====
// Microdegree to binary angle conversion followed by a pipelined rotation CORDIC.
module csb_sincos import csb_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [DLON_W-1:0] ang_i,
  output q30_t                     sin_o,
  output q30_t                     cos_o
);

  localparam int unsigned M_W  = DLON_W - 1;
  localparam int unsigned PK_W = M_W + 32;
  localparam int unsigned PR_W = 58;
  localparam int unsigned XY_W = 34;
  localparam int unsigned Z_W  = 33;

  // 2^32 = 11 * TURN_DIV + TURN_REM; RECIP_K = floor(TURN_REM * 2^32 / TURN_DIV)
  localparam logic [31:0]     RECIP_K  = 32'd3996315504;
  localparam logic [28:0]     TURN_REM = 29'd334967296;
  localparam logic [28:0]     TURN_DIV = 29'd360000000;
  localparam logic [PR_W-1:0] HALF_DIV = PR_W'(180000000);
  localparam logic [31:0]     TURN_INT = 32'd11;
  localparam logic signed [XY_W-1:0] GAIN = XY_W'(652032874);

  logic [M_W-1:0]  m1_q;
  logic            neg1_q;
  logic [PK_W-1:0] pk2_q;
  logic [PR_W-1:0] pr2_q;
  logic [31:0]     m11_2_q;
  logic            neg2_q;
  logic [M_W-1:0]  e0;
  logic [M_W-1:0]  e0_3_q;
  logic [PR_W-1:0] ed3_q;
  logic [PR_W-1:0] pr3_q;
  logic [31:0]     m11_3_q;
  logic            neg3_q;
  logic [PR_W-1:0] rem;
  logic [31:0]     sum4_q;
  logic            corr4_q;
  logic            neg4_q;
  logic [31:0]     qv;
  logic [31:0]     bam5_q;
  logic [1:0]      quad;
  logic            flip;
  logic [31:0]     za;
  logic signed [Z_W-1:0] z0_q;
  logic                  flip0_q;

  logic signed [XY_W-1:0] x_q [STAGES];
  logic signed [XY_W-1:0] y_q [STAGES];
  logic signed [Z_W-1:0]  z_q [STAGES];
  logic                   fl_q [STAGES];
  q30_t                   sin_q;
  q30_t                   cos_q;

  assign e0   = pk2_q[PK_W-1 -: M_W];
  assign rem  = pr3_q - ed3_q;
  assign qv   = sum4_q + 32'(corr4_q);
  assign quad = bam5_q[31:30];
  assign flip = (quad == 2'd1) || (quad == 2'd2);
  assign za   = bam5_q + (flip ? 32'h8000_0000 : 32'h0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= ang_i[DLON_W-1];
      m1_q    <= ang_i[DLON_W-1] ? M_W'(-ang_i) : M_W'(ang_i);
      pk2_q   <= PK_W'(m1_q) * PK_W'(RECIP_K);
      pr2_q   <= PR_W'(m1_q) * PR_W'(TURN_REM) + HALF_DIV;
      m11_2_q <= 32'(m1_q) * TURN_INT;
      neg2_q  <= neg1_q;
      e0_3_q  <= e0;
      ed3_q   <= PR_W'(e0) * PR_W'(TURN_DIV);
      pr3_q   <= pr2_q;
      m11_3_q <= m11_2_q;
      neg3_q  <= neg2_q;
      // estimate is low by at most one
      corr4_q <= rem >= PR_W'(TURN_DIV);
      sum4_q  <= m11_3_q + 32'(e0_3_q);
      neg4_q  <= neg3_q;
      bam5_q  <= neg4_q ? -qv : qv;
      // fold the left half-plane onto the right by a half-turn
      z0_q    <= {za[31], za};
      flip0_q <= flip;
    end
  end

  for (genvar gi = 0; gi < STAGES; gi++) begin : g_rot
    logic signed [XY_W-1:0] xin;
    logic signed [XY_W-1:0] yin;
    logic signed [Z_W-1:0]  zin;
    logic                   fin;
    logic signed [Z_W-1:0]  atn;

    if (gi == 0) begin : g_first
      assign xin = GAIN;
      assign yin = '0;
      assign zin = z0_q;
      assign fin = flip0_q;
    end else begin : g_next
      assign xin = x_q[gi-1];
      assign yin = y_q[gi-1];
      assign zin = z_q[gi-1];
      assign fin = fl_q[gi-1];
    end
    assign atn = signed'({1'b0, ATAN_BAM[gi]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zin[Z_W-1]) begin
          x_q[gi] <= xin - (yin >>> gi);
          y_q[gi] <= yin + (xin >>> gi);
          z_q[gi] <= zin - atn;
        end else begin
          x_q[gi] <= xin + (yin >>> gi);
          y_q[gi] <= yin - (xin >>> gi);
          z_q[gi] <= zin + atn;
        end
        fl_q[gi] <= fin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= fl_q[STAGES-1] ? 32'(-y_q[STAGES-1]) : 32'(y_q[STAGES-1]);
      cos_q <= fl_q[STAGES-1] ? 32'(-x_q[STAGES-1]) : 32'(x_q[STAGES-1]);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== rtl/core/csb_atan2.sv =====
// Pipelined vectoring CORDIC giving atan2 as a binary angle.
module csb_atan2 import csb_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [NUM_W-1:0] y_i,
  input  logic signed [DEN_W-1:0] x_i,
  output logic [31:0]             bearing_o
);

  localparam int unsigned V_W = 36;

  logic signed [V_W-1:0] xe;
  logic signed [V_W-1:0] ye;
  logic signed [V_W-1:0] x0_q;
  logic signed [V_W-1:0] y0_q;
  logic                  base0_q;
  logic                  zero0_q;

  logic signed [V_W-1:0] x_q [STAGES];
  logic signed [V_W-1:0] y_q [STAGES];
  logic [31:0]           z_q [STAGES];
  logic                  base_q [STAGES];
  logic                  zero_q [STAGES];
  logic [31:0]           bearing_q;

  assign xe = V_W'(x_i);
  assign ye = V_W'(y_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero0_q <= (x_i == '0) && (y_i == '0);
      base0_q <= x_i[DEN_W-1];
      x0_q    <= x_i[DEN_W-1] ? -xe : xe;
      y0_q    <= x_i[DEN_W-1] ? -ye : ye;
    end
  end

  for (genvar gi = 0; gi < STAGES; gi++) begin : g_vec
    logic signed [V_W-1:0] xin;
    logic signed [V_W-1:0] yin;
    logic [31:0]           zin;
    logic                  bin;
    logic                  nin;
    logic                  ypos;

    if (gi == 0) begin : g_first
      assign xin = x0_q;
      assign yin = y0_q;
      assign zin = '0;
      assign bin = base0_q;
      assign nin = zero0_q;
    end else begin : g_next
      assign xin = x_q[gi-1];
      assign yin = y_q[gi-1];
      assign zin = z_q[gi-1];
      assign bin = base_q[gi-1];
      assign nin = zero_q[gi-1];
    end
    assign ypos = !yin[V_W-1] && (yin != '0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ypos) begin
          x_q[gi] <= xin + (yin >>> gi);
          y_q[gi] <= yin - (xin >>> gi);
          z_q[gi] <= zin + ATAN_BAM[gi];
        end else begin
          x_q[gi] <= xin - (yin >>> gi);
          y_q[gi] <= yin + (xin >>> gi);
          z_q[gi] <= zin - ATAN_BAM[gi];
        end
        base_q[gi] <= bin;
        zero_q[gi] <= nin;
      end
    end
  end

  // both operands zero reads as north
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bearing_q <= zero_q[STAGES-1] ? '0 : {base_q[STAGES-1], 31'd0} + z_q[STAGES-1];
    end
  end

  assign bearing_o = bearing_q;

endmodule

// ===== rtl/core/compass_sector_from_bearing_unit.sv =====
// Top level: eight-point compass sector of the initial great-circle bearing. Takes
// one position pair per cycle while the skid stage is free and returns one direction
// word per pair, in order. The depth is set by the two unrolled CORDIC pipelines
// (rotation for the sines and cosines, vectoring for atan2) plus conversion, product
// and classification stages. The whole pipeline advances together; an output register
// and a one-word skid stage let it keep accepting while a result waits. Direction 8
// marks a point within 100 microdegrees of an axis, or two points closer than 10
// microdegrees in both deltas. The user must write cardinal_half_width through the
// cfg port while the unit is idle; the unit does not enforce this.
module compass_sector_from_bearing_unit import csb_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [LAT_W-1:0] from_lat_i,
  input  logic signed [LON_W-1:0] from_lon_i,
  input  logic signed [LAT_W-1:0] to_lat_i,
  input  logic signed [LON_W-1:0] to_lon_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DIR_W-1:0]        direction_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [HW_W-1:0]         cfg_data_i
);

  localparam int unsigned SC_LAT  = CORDIC_STAGES + 7;
  localparam int unsigned AT_LAT  = CORDIC_STAGES + 2;
  localparam int unsigned ST_M1   = 2 + SC_LAT;
  localparam int unsigned ST_M3   = ST_M1 + 2;
  localparam int unsigned ST_X1   = ST_M3 + AT_LAT + 1;
  localparam int unsigned ST_X2   = ST_X1 + 1;
  localparam int unsigned NSTG    = ST_X2 + 1;
  localparam int unsigned UNK_LEN = ST_X2 - 2;
  localparam int unsigned DLAT_W  = LAT_W + 1;
  localparam int unsigned BM_W    = 41;

  localparam logic [HW_W-1:0]  HW_RESET = HW_W'(30);
  localparam logic [DIR_W-1:0] DIR_N    = DIR_W'(0);
  localparam logic [DIR_W-1:0] DIR_UNK  = DIR_W'(8);

  localparam logic signed [LAT_W-1:0]  NEAR_LAT = LAT_W'(100);
  localparam logic signed [LON_W-1:0]  NEAR_LON = LON_W'(100);
  localparam logic signed [DLAT_W-1:0] COIN_LAT = DLAT_W'(10);
  localparam logic signed [DLON_W-1:0] COIN_LON = DLON_W'(10);

  function automatic logic [DIR_W-1:0] classify(input logic [BM_W-1:0] b,
                                                input logic [HW_W-1:0] w);
    logic [41:0]      bx;
    logic [9:0]       wd;
    logic [9:0]       lo;
    logic [9:0]       hi;
    logic [DIR_W-1:0] res;
    logic             hit;
    bx  = 42'(b);
    wd  = 10'(w);
    res = DIR_UNK;
    hit = 1'b0;
    if (bx <= {wd, 32'd0} || bx >= {10'd360 - wd, 32'd0}) begin
      res = DIR_N;
      hit = 1'b1;
    end
    for (int k = 1; k < 8; k++) begin
      if ((k & 1) == 1) begin
        lo = 10'(45 * (k - 1)) + wd;
        hi = 10'(45 * (k + 1)) - wd;
      end else begin
        lo = 10'(45 * k) - wd;
        hi = 10'(45 * k) + wd;
      end
      // the last diagonal stops short of its upper edge
      if (!hit && bx > {lo, 32'd0} &&
          ((k == 7) ? (bx < {hi, 32'd0}) : (bx <= {hi, 32'd0}))) begin
        res = DIR_W'(k);
        hit = 1'b1;
      end
    end
    return res;
  endfunction

  logic                    adv;
  logic [NSTG-1:0]         v_q;
  logic [HW_W-1:0]         hw_q;

  logic signed [LAT_W-1:0]  lat1_0_q;
  logic signed [LON_W-1:0]  lon1_0_q;
  logic signed [LAT_W-1:0]  lat2_0_q;
  logic signed [LON_W-1:0]  lon2_0_q;
  logic signed [LAT_W-1:0]  lat1_1_q;
  logic signed [LAT_W-1:0]  lat2_1_q;
  logic signed [DLON_W-1:0] dlon1_q;
  logic signed [DLAT_W-1:0] dlat1_q;
  logic                     bad1_q;
  logic                     bad;
  logic                     coin;
  logic                     unk_q [UNK_LEN];

  q30_t s1;
  q30_t c1;
  q30_t s2;
  q30_t c2;
  q30_t sd;
  q30_t cd;

  logic signed [63:0]        p_num;
  logic signed [63:0]        p_a;
  logic signed [63:0]        p_b;
  logic signed [NUM_W+31:0]  p_bc;
  logic signed [NUM_W-1:0]   num_m1_q;
  logic signed [NUM_W-1:0]   a_m1_q;
  logic signed [NUM_W-1:0]   b_m1_q;
  q30_t                      cd_m1_q;
  logic signed [NUM_W-1:0]   num_m2_q;
  logic signed [NUM_W-1:0]   a_m2_q;
  logic signed [DEN_W-1:0]   p2_m2_q;
  logic signed [NUM_W-1:0]   num_m3_q;
  logic signed [DEN_W-1:0]   den_m3_q;
  logic [31:0]               bearing;
  logic [BM_W-1:0]           bm_x1_q;
  logic [DIR_W-1:0]          dir_x2_q;

  logic                      out_v_q;
  logic [DIR_W-1:0]          out_d_q;
  logic                      skid_v_q;
  logic [DIR_W-1:0]          skid_d_q;

  // advance whenever the skid stage is free
  assign adv         = !skid_v_q;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HW_RESET;
    end else if (cfg_valid_i) begin
      hw_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  assign bad = (lat1_0_q >= -NEAR_LAT && lat1_0_q <= NEAR_LAT) ||
               (lon1_0_q >= -NEAR_LON && lon1_0_q <= NEAR_LON) ||
               (lat2_0_q >= -NEAR_LAT && lat2_0_q <= NEAR_LAT) ||
               (lon2_0_q >= -NEAR_LON && lon2_0_q <= NEAR_LON);
  assign coin = (dlat1_q > -COIN_LAT) && (dlat1_q < COIN_LAT) &&
                (dlon1_q > -COIN_LON) && (dlon1_q < COIN_LON);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lat1_0_q <= from_lat_i;
      lon1_0_q <= from_lon_i;
      lat2_0_q <= to_lat_i;
      lon2_0_q <= to_lon_i;
      lat1_1_q <= lat1_0_q;
      lat2_1_q <= lat2_0_q;
      dlon1_q  <= DLON_W'(lon2_0_q) - DLON_W'(lon1_0_q);
      dlat1_q  <= DLAT_W'(lat2_0_q) - DLAT_W'(lat1_0_q);
      bad1_q   <= bad;
      unk_q[0] <= bad1_q || coin;
      for (int j = 1; j < UNK_LEN; j++) begin
        unk_q[j] <= unk_q[j-1];
      end
    end
  end

  csb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i (DLON_W'(lat1_1_q)),
    .sin_o (s1),
    .cos_o (c1)
  );

  csb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat2 (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i (DLON_W'(lat2_1_q)),
    .sin_o (s2),
    .cos_o (c2)
  );

  csb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i (dlon1_q),
    .sin_o (sd),
    .cos_o (cd)
  );

  assign p_num = sd * c2;
  assign p_a   = c1 * s2;
  assign p_b   = s1 * c2;
  assign p_bc  = b_m1_q * cd_m1_q;

  // Q4.60 products, floor-shifted back to Q4.30
  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_m1_q <= NUM_W'(p_num >>> 30);
      a_m1_q   <= NUM_W'(p_a >>> 30);
      b_m1_q   <= NUM_W'(p_b >>> 30);
      cd_m1_q  <= cd;
      num_m2_q <= num_m1_q;
      a_m2_q   <= a_m1_q;
      p2_m2_q  <= DEN_W'(p_bc >>> 30);
      num_m3_q <= num_m2_q;
      den_m3_q <= DEN_W'(a_m2_q) - p2_m2_q;
    end
  end

  csb_atan2 #(.STAGES(CORDIC_STAGES)) u_atan2 (
    .clk_i     (clk_i),
    .en_i      (adv),
    .y_i       (num_m3_q),
    .x_i       (den_m3_q),
    .bearing_o (bearing)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bm_x1_q  <= BM_W'(bearing) * BM_W'(360);
      dir_x2_q <= unk_q[UNK_LEN-1] ? DIR_UNK : classify(bm_x1_q, hw_q);
    end
  end

  // output register with a one-word skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= v_q[NSTG-1];
      end
    end else if (v_q[NSTG-1] && adv) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_d_q <= skid_v_q ? skid_d_q : dir_x2_q;
    end else if (adv) begin
      skid_d_q <= dir_x2_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign direction_o = out_d_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held with the output register empty");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(v_q))
    else $error("pipeline moved while the skid stage was full");

  a_unknown_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v_q[ST_X1] && unk_q[UNK_LEN-1]) |=> (dir_x2_q == DIR_UNK))
    else $error("flagged pair not classed as unknown");

  a_no_invented_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_v_q && !skid_v_q && !v_q[NSTG-1]) |=> !out_v_q)
    else $error("output word appeared from an empty pipeline");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (direction_o <= DIR_UNK))
    else $error("direction code out of range");

endmodule
